FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on aclk.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every edge outside reset.
`define PCVS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check on every edge, reset included.
`define PCVS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: src/pcvs_pkg.sv
// ---------------------------------------------------------------------------
// pcvs_pkg
// Widths, codes and types shared by the velocity-form PI controller.
// ---------------------------------------------------------------------------
package pcvs_pkg;

    // Core sizing
    localparam int ERR_WIDTH = 16;
    localparam int ACC_WIDTH = 32;
    localparam int FRAC_BITS = 8;

    // Fixed field widths
    localparam int S_DATA_W   = 16;
    localparam int DRIVE_W    = 32;
    localparam int GAIN_W     = 16;
    localparam int MODE_W     = 2;
    localparam int LIMIT_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Datapath widths
    localparam int DIFF_W    = ERR_WIDTH + 1;
    localparam int PROD_W    = GAIN_W + DIFF_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int INC_W     = SUM_W - FRAC_BITS;
    localparam int STATE_W   = (ACC_WIDTH > LIMIT_W) ? ACC_WIDTH : LIMIT_W;
    localparam int WIDE_BASE = (STATE_W > INC_W) ? STATE_W : INC_W;
    localparam int WIDE_W    = WIDE_BASE + 1;

    // Accumulator range at ACC_WIDTH, held in the wide adder format
    localparam logic signed [WIDE_W-1:0] ACC_HI =
        WIDE_W'({1'b0, {(ACC_WIDTH-1){1'b1}}});
    localparam logic signed [WIDE_W-1:0] ACC_LO = ~ACC_HI;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KP    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KIT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = CFG_IDX_W'(4);

    // Limit modes
    localparam logic [MODE_W-1:0] LIMIT_NONE  = MODE_W'(0);
    localparam logic [MODE_W-1:0] LIMIT_CLAMP = MODE_W'(1);
    localparam logic [MODE_W-1:0] LIMIT_WRAP  = MODE_W'(2);

    typedef struct packed {
        logic signed [GAIN_W-1:0]  kp;
        logic signed [GAIN_W-1:0]  kit;
        logic [MODE_W-1:0]         mode;
        logic signed [LIMIT_W-1:0] lower;
        logic signed [LIMIT_W-1:0] upper;
    } cfg_t;

    // Take the error from the stream field: low ERR_WIDTH bits, zero above the field
    function automatic logic signed [ERR_WIDTH-1:0] err_from_field(
        input logic [S_DATA_W-1:0] field
    );
        logic signed [ERR_WIDTH-1:0] res;
        int                          j;
        for (int i = 0; i < ERR_WIDTH; i++) begin
            j      = (i < S_DATA_W) ? i : 0;
            res[i] = (i < S_DATA_W) ? field[j] : 1'b0;
        end
        return res;
    endfunction

endpackage

FILE: src/pcvs_increment.sv
// ---------------------------------------------------------------------------
// pcvs_increment
// Error register, then kp*diff + kit*prev floored by 2^FRAC_BITS.
// ---------------------------------------------------------------------------
module pcvs_increment (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [pcvs_pkg::ERR_WIDTH-1:0]  in_error,
    input  pcvs_pkg::cfg_t                         cfg,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [pcvs_pkg::INC_W-1:0]      out_inc
);

    logic                                  v1_reg;
    logic signed [pcvs_pkg::DIFF_W-1:0]    diff_reg;
    logic signed [pcvs_pkg::ERR_WIDTH-1:0] prev_use_reg;
    logic signed [pcvs_pkg::ERR_WIDTH-1:0] prev_err_reg;
    logic                                  v2_reg;
    logic signed [pcvs_pkg::INC_W-1:0]     inc_reg;

    logic                                  adv1;
    logic                                  adv2;
    logic                                  accept;
    logic signed [pcvs_pkg::DIFF_W-1:0]    diff_next;
    logic signed [pcvs_pkg::PROD_W-1:0]    prod_p;
    logic signed [pcvs_pkg::PROD_W-1:0]    prod_i;
    logic signed [pcvs_pkg::SUM_W-1:0]     sum;
    logic signed [pcvs_pkg::INC_W-1:0]     inc_next;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;
    assign accept   = in_valid && adv1;

    assign diff_next = pcvs_pkg::DIFF_W'(in_error) - pcvs_pkg::DIFF_W'(prev_err_reg);

    assign prod_p   = pcvs_pkg::PROD_W'(cfg.kp) * pcvs_pkg::PROD_W'(diff_reg);
    assign prod_i   = pcvs_pkg::PROD_W'(cfg.kit) * pcvs_pkg::PROD_W'(prev_use_reg);
    assign sum      = pcvs_pkg::SUM_W'(prod_p) + pcvs_pkg::SUM_W'(prod_i);
    // dropping the fraction bits of a two's complement value is a floor
    assign inc_next = $signed(sum[pcvs_pkg::SUM_W-1:pcvs_pkg::FRAC_BITS]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            prev_err_reg <= '0;
        end else begin
            if (adv1) begin
                v1_reg <= in_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (accept) begin
                prev_err_reg <= in_error;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            diff_reg     <= diff_next;
            prev_use_reg <= prev_err_reg;
        end
        if (adv2 && v1_reg) begin
            inc_reg <= inc_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_inc   = inc_reg;

endmodule

FILE: src/pcvs_accumulate.sv
// ---------------------------------------------------------------------------
// pcvs_accumulate
// Saturating accumulate, limit by mode, output word register.
// ---------------------------------------------------------------------------
module pcvs_accumulate (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pcvs_pkg::INC_W-1:0]     in_inc,
    input  pcvs_pkg::cfg_t                        cfg,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [pcvs_pkg::DRIVE_W-1:0]          m_drive
);

    logic signed [pcvs_pkg::STATE_W-1:0] acc_reg;
    logic signed [pcvs_pkg::STATE_W-1:0] acc_next;
    logic                                out_valid_reg;
    logic [pcvs_pkg::DRIVE_W-1:0]        drive_reg;

    logic                                load;
    logic signed [pcvs_pkg::WIDE_W-1:0]  wide_sum;
    logic signed [pcvs_pkg::STATE_W-1:0] sat;
    logic signed [pcvs_pkg::STATE_W-1:0] lim_lo;
    logic signed [pcvs_pkg::STATE_W-1:0] lim_hi;

    assign in_ready = !out_valid_reg || m_ready;
    assign load     = in_valid && in_ready;

    assign wide_sum = pcvs_pkg::WIDE_W'(acc_reg) + pcvs_pkg::WIDE_W'(in_inc);
    assign lim_lo   = pcvs_pkg::STATE_W'(cfg.lower);
    assign lim_hi   = pcvs_pkg::STATE_W'(cfg.upper);

    always_comb begin
        if (wide_sum > pcvs_pkg::ACC_HI) begin
            sat = pcvs_pkg::STATE_W'(pcvs_pkg::ACC_HI);
        end else if (wide_sum < pcvs_pkg::ACC_LO) begin
            sat = pcvs_pkg::STATE_W'(pcvs_pkg::ACC_LO);
        end else begin
            sat = pcvs_pkg::STATE_W'(wide_sum);
        end

        acc_next = sat;
        case (cfg.mode)
            pcvs_pkg::LIMIT_CLAMP: begin
                if (sat > lim_hi) begin
                    acc_next = lim_hi;
                end else if (sat < lim_lo) begin
                    acc_next = lim_lo;
                end
            end
            pcvs_pkg::LIMIT_WRAP: begin
                if (sat > lim_hi) begin
                    acc_next = lim_lo;
                end else if (sat < lim_lo) begin
                    acc_next = lim_hi;
                end
            end
            default: begin
                acc_next = sat;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
            if (load) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            drive_reg <= acc_next[pcvs_pkg::DRIVE_W-1:0];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_drive = drive_reg;

endmodule

FILE: src/pi_controller_velocity_sat.sv
// ---------------------------------------------------------------------------
// pi_controller_velocity_sat
// Incremental PI controller with width saturation and output limiting.
// ---------------------------------------------------------------------------
// Takes one signed error word per cycle and returns one drive word for each,
// in order. A word is accepted every clock while the output side keeps up;
// each result passes the difference, increment and drive registers. The rate
// is set by the accumulator loop: add, saturate to the accumulator width and
// limit are combinational into the accumulator register, so words can follow
// back to back. The two multiplies sit in a stage of their own ahead of that loop.
// Gains are signed Q8.8, error and drive are integers; the increment is
// floored toward minus infinity. Write the configuration registers only
// while no word is in flight. There is no clearing pass after reset.
// ---------------------------------------------------------------------------
module pi_controller_velocity_sat (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pcvs_pkg::S_DATA_W-1:0]        s_tdata,    // [15:0] error_sample
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pcvs_pkg::DRIVE_W-1:0]         m_tdata,    // [31:0] drive
    // register write port
    input  logic                                 cfg_we,
    input  logic [pcvs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pcvs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    pcvs_pkg::cfg_t                        cfg_reg;
    pcvs_pkg::cfg_t                        cfg_next;

    logic signed [pcvs_pkg::ERR_WIDTH-1:0] in_error;
    logic                                  inc_valid;
    logic                                  inc_ready;
    logic signed [pcvs_pkg::INC_W-1:0]     inc_value;

    // Register decode: a write lands on the named field, other indexes drop
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                pcvs_pkg::CFG_KP:    cfg_next.kp    = cfg_data[pcvs_pkg::GAIN_W-1:0];
                pcvs_pkg::CFG_KIT:   cfg_next.kit   = cfg_data[pcvs_pkg::GAIN_W-1:0];
                pcvs_pkg::CFG_MODE:  cfg_next.mode  = cfg_data[pcvs_pkg::MODE_W-1:0];
                pcvs_pkg::CFG_LOWER: cfg_next.lower = cfg_data[pcvs_pkg::LIMIT_W-1:0];
                pcvs_pkg::CFG_UPPER: cfg_next.upper = cfg_data[pcvs_pkg::LIMIT_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // Reset to zero gains, no limiting and the full 32-bit limit range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp    <= '0;
            cfg_reg.kit   <= '0;
            cfg_reg.mode  <= pcvs_pkg::LIMIT_NONE;
            cfg_reg.lower <= {1'b1, {(pcvs_pkg::LIMIT_W-1){1'b0}}};
            cfg_reg.upper <= {1'b0, {(pcvs_pkg::LIMIT_W-1){1'b1}}};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Take the error from the low bits of the word
    assign in_error = pcvs_pkg::err_from_field(s_tdata);

    // Hold e_prev, form the floored increment
    pcvs_increment u_increment (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_error  (in_error),
        .cfg       (cfg_reg),
        .out_valid (inc_valid),
        .out_ready (inc_ready),
        .out_inc   (inc_value)
    );

    // Advance the accumulator and register the drive word
    pcvs_accumulate u_accumulate (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (inc_valid),
        .in_ready (inc_ready),
        .in_inc   (inc_value),
        .cfg      (cfg_reg),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_drive  (m_tdata)
    );

endmodule

FILE: src/pcvs_checker.sv
// ---------------------------------------------------------------------------
// pcvs_checker
// Port-level checks for the PI controller, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pcvs_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [pcvs_pkg::DRIVE_W-1:0]      m_tdata,
    input logic                              cfg_we,
    input logic [pcvs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [pcvs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [pcvs_pkg::MODE_W-1:0]         mode_reg;
    logic signed [pcvs_pkg::LIMIT_W-1:0] lower_reg;
    logic signed [pcvs_pkg::LIMIT_W-1:0] upper_reg;
    logic                                limited;
    logic                                new_word;

    // Shadow the limit registers from the write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= pcvs_pkg::LIMIT_NONE;
            lower_reg <= {1'b1, {(pcvs_pkg::LIMIT_W-1){1'b0}}};
            upper_reg <= {1'b0, {(pcvs_pkg::LIMIT_W-1){1'b1}}};
        end else if (cfg_we) begin
            if (cfg_index == pcvs_pkg::CFG_MODE) begin
                mode_reg <= cfg_data[pcvs_pkg::MODE_W-1:0];
            end
            if (cfg_index == pcvs_pkg::CFG_LOWER) begin
                lower_reg <= cfg_data[pcvs_pkg::LIMIT_W-1:0];
            end
            if (cfg_index == pcvs_pkg::CFG_UPPER) begin
                upper_reg <= cfg_data[pcvs_pkg::LIMIT_W-1:0];
            end
        end
    end

    assign limited  = (mode_reg == pcvs_pkg::LIMIT_CLAMP
                       || mode_reg == pcvs_pkg::LIMIT_WRAP)
                      && (lower_reg <= upper_reg);
    assign new_word = s_tvalid || s_tready || m_tvalid;

    `PCVS_ASSERT_ALWAYS(a_reset_empty,
        !aresetn |=> (!m_tvalid && s_tready),
        "pipeline not empty after reset")
    `PCVS_ASSERT(a_hold_valid, (m_tvalid && !m_tready) |=> m_tvalid,
        "drive word dropped while stalled")
    `PCVS_ASSERT(a_hold_data, (m_tvalid && !m_tready) |=> $stable(m_tdata),
        "stalled drive word changed")
    `PCVS_ASSERT(a_in_limits,
        (new_word && m_tvalid && $past(!m_tvalid || m_tready) && $past(limited))
        |-> ($signed(m_tdata) >= $past(lower_reg)
             && $signed(m_tdata) <= $past(upper_reg)),
        "drive outside limits")

endmodule

bind pi_controller_velocity_sat pcvs_checker u_pcvs_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

FILE: verif/pi_controller_velocity_sat_test.sv
// ----------------------------------------------------------------------------
// pi_controller_velocity_sat_test
// Self-checking stream testbench for the velocity-form PI controller.
// ----------------------------------------------------------------------------
// Error words go in through the input stream in random bursts with random
// gaps. The drive stream is stalled on a pattern that changes from phase to
// phase. A behavioral copy of the controller runs beside the block, and every
// drive word is compared with the oldest prediction. Register settings change
// only while no word is in flight.
// ----------------------------------------------------------------------------
module pi_controller_velocity_sat_test;
    import pcvs_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;      // pipeline is three deep, keep margin
    localparam int RANDOM_ITEMS  = 800;

    localparam logic signed [LIMIT_W-1:0]   LIMIT_TOP    = {1'b0, {(LIMIT_W-1){1'b1}}};
    localparam logic signed [LIMIT_W-1:0]   LIMIT_BOTTOM = ~LIMIT_TOP;
    localparam logic signed [GAIN_W-1:0]    GAIN_TOP     = {1'b0, {(GAIN_W-1){1'b1}}};
    localparam logic signed [GAIN_W-1:0]    GAIN_BOTTOM  = ~GAIN_TOP;
    localparam logic signed [GAIN_W-1:0]    GAIN_ONE     = GAIN_W'(1 << FRAC_BITS);
    localparam logic signed [ERR_WIDTH-1:0] ERR_TOP      = {1'b0, {(ERR_WIDTH-1){1'b1}}};
    localparam logic signed [ERR_WIDTH-1:0] ERR_BOTTOM   = ~ERR_TOP;
    // Unused mode code; the block must leave the accumulator unlimited
    localparam logic [MODE_W-1:0]           LIMIT_SPARE  = MODE_W'(3);

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PERIODIC} ready_style_e;
    typedef enum int {ERR_FULL, ERR_SMALL, ERR_STEADY, ERR_CORNER} err_style_e;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [S_DATA_W-1:0]      s_tdata   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [DRIVE_W-1:0]       m_tdata;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data  = '0;

    // Register shadows and controller state of the behavioral copy
    logic signed [GAIN_W-1:0]    kp_set;
    logic signed [GAIN_W-1:0]    kit_set;
    logic [MODE_W-1:0]           mode_set;
    logic signed [LIMIT_W-1:0]   lower_set;
    logic signed [LIMIT_W-1:0]   upper_set;
    logic signed [ACC_WIDTH-1:0] acc_model;
    logic signed [ERR_WIDTH-1:0] last_error;

    // Drive words predicted but not yet seen on the result stream
    logic [DRIVE_W-1:0] pending_drive[$];

    int           mismatches   = 0;
    int           cycle_count  = 0;
    int           burst_left   = 0;
    bit           gaps_on      = 1'b1;
    ready_style_e ready_style  = READY_RANDOM;
    int           ready_period = 5;
    int           ready_hold   = 2;

    always #5 aclk = ~aclk;

    pi_controller_velocity_sat dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Count cycles and stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("pi_controller_velocity_sat verification failed");
            $finish;
        end
    end

    // Receiver back-pressure: always ready, random stalls, or a fixed duty pattern
    always @(posedge aclk) begin
        case (ready_style)
            READY_ALWAYS: begin
                m_tready <= 1'b1;
            end
            READY_RANDOM: begin
                m_tready <= ($urandom_range(0, 99) >= 30);
            end
            default: begin
                m_tready <= ((cycle_count % ready_period) >= ready_hold);
            end
        endcase
    end

    // Compare each accepted drive word with the oldest prediction
    always @(posedge aclk) begin : check_drive
        logic [DRIVE_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_drive.size() == 0) begin
                $display("%0t: unexpected drive word: expected none, actual %0d",
                         $time, $signed(m_tdata));
                mismatches++;
            end else begin
                want = pending_drive.pop_front();
                if (m_tdata !== want) begin
                    $display("%0t: drive mismatch: expected %0d, actual %0d",
                             $time, $signed(want), $signed(m_tdata));
                    mismatches++;
                end
            end
        end
    end

    // Advance the behavioral controller by one error sample and queue the drive
    function automatic void advance_controller(input logic signed [ERR_WIDTH-1:0] e);
        longint diff;
        longint sum;
        longint step;
        longint total;
        longint acc_top;
        longint acc_bottom;
        acc_top    = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
        acc_bottom = -acc_top - 1;
        diff  = longint'(e) - longint'(last_error);
        sum   = longint'(kp_set) * diff + longint'(kit_set) * longint'(last_error);
        // Arithmetic shift floors toward minus infinity
        step  = sum >>> FRAC_BITS;
        total = longint'(acc_model) + step;
        // Saturate at the accumulator width before any limit
        if (total > acc_top) begin
            total = acc_top;
        end else if (total < acc_bottom) begin
            total = acc_bottom;
        end
        // Upper bound is tested first, also when the limits are crossed
        case (mode_set)
            LIMIT_CLAMP: begin
                if (total > longint'(upper_set)) begin
                    total = upper_set;
                end else if (total < longint'(lower_set)) begin
                    total = lower_set;
                end
            end
            LIMIT_WRAP: begin
                if (total > longint'(upper_set)) begin
                    total = lower_set;
                end else if (total < longint'(lower_set)) begin
                    total = upper_set;
                end
            end
            default: begin
            end
        endcase
        acc_model  = total[ACC_WIDTH-1:0];
        last_error = e;
        pending_drive.push_back(acc_model[DRIVE_W-1:0]);
    endfunction

    // Offer one error word; open a new burst, after a gap if gaps are on, when the last one ran out.
    // Valid stays high after acceptance so back-to-back words need no re-raise.
    task automatic send_error(input logic signed [ERR_WIDTH-1:0] e);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                gap = $urandom_range(1, 6);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= e;
        do @(posedge aclk); while (!s_tready);
        advance_controller(e);
    endtask

    // Drop valid, hold until every predicted word has arrived, then let the pipe settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_drive.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Raise one register write for one edge; the caller drops the enable
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        case (idx)
            CFG_KP:    kp_set    = value[GAIN_W-1:0];
            CFG_KIT:   kit_set   = value[GAIN_W-1:0];
            CFG_MODE:  mode_set  = value[MODE_W-1:0];
            CFG_LOWER: lower_set = value[LIMIT_W-1:0];
            CFG_UPPER: upper_set = value[LIMIT_W-1:0];
            default:   ;
        endcase
    endtask

    // Drain the block, then write all five registers
    task automatic apply_settings(input logic signed [GAIN_W-1:0]  kp,
                                  input logic signed [GAIN_W-1:0]  kit,
                                  input logic [MODE_W-1:0]         mode,
                                  input logic signed [LIMIT_W-1:0] lower,
                                  input logic signed [LIMIT_W-1:0] upper);
        wait_idle();
        write_reg(CFG_KP,    CFG_DATA_W'(kp));
        write_reg(CFG_KIT,   CFG_DATA_W'(kit));
        write_reg(CFG_MODE,  CFG_DATA_W'(mode));
        write_reg(CFG_LOWER, CFG_DATA_W'(lower));
        write_reg(CFG_UPPER, CFG_DATA_W'(upper));
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return GAIN_BOTTOM;
            1:       return GAIN_TOP;
            2:       return '0;
            3:       return GAIN_W'(int'($urandom_range(0, 1024)) - 512);
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return LIMIT_BOTTOM;
            1:       return LIMIT_TOP;
            2:       return LIMIT_W'(int'($urandom_range(0, 20000)) - 10000);
            3:       return LIMIT_W'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
            default: return LIMIT_W'($urandom);
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        case ($urandom_range(0, 9))
            0, 1:       return LIMIT_NONE;
            2, 3, 4, 5: return LIMIT_CLAMP;
            6, 7, 8:    return LIMIT_WRAP;
            default:    return LIMIT_SPARE;
        endcase
    endfunction

    // Next error word for a phase; a steady style models a slowly moving setpoint
    function automatic logic signed [ERR_WIDTH-1:0] next_error(
        input err_style_e                    style,
        inout logic signed [ERR_WIDTH-1:0]   steady
    );
        case (style)
            ERR_SMALL: begin
                return ERR_WIDTH'(int'($urandom_range(0, 600)) - 300);
            end
            ERR_STEADY: begin
                if ($urandom_range(0, 9) == 0) begin
                    steady = ERR_WIDTH'($urandom);
                end
                return steady + ERR_WIDTH'(int'($urandom_range(0, 8)) - 4);
            end
            ERR_CORNER: begin
                case ($urandom_range(0, 4))
                    0:       return ERR_TOP;
                    1:       return ERR_BOTTOM;
                    2:       return '0;
                    3:       return '1;
                    default: return ERR_WIDTH'($urandom);
                endcase
            end
            default: begin
                return ERR_WIDTH'($urandom);
            end
        endcase
    endfunction

    // Gains reset to zero, so every drive word stays at zero
    task automatic test_reset_defaults();
        send_error(ERR_TOP);
        send_error(ERR_BOTTOM);
    endtask

    // Full-scale error swings under unit and extreme gains
    task automatic test_gain_extremes();
        apply_settings(GAIN_ONE, GAIN_ONE >>> 2, LIMIT_NONE, LIMIT_BOTTOM, LIMIT_TOP);
        send_error(ERR_TOP);
        send_error(ERR_BOTTOM);
        send_error('0);
        send_error('1);
        apply_settings(GAIN_BOTTOM, GAIN_TOP, LIMIT_NONE, LIMIT_BOTTOM, LIMIT_TOP);
        send_error(ERR_TOP);
        send_error(ERR_BOTTOM);
        apply_settings(GAIN_TOP, GAIN_BOTTOM, LIMIT_NONE, LIMIT_BOTTOM, LIMIT_TOP);
        send_error(ERR_BOTTOM);
        send_error(ERR_TOP);
    endtask

    // Unit gains make the increment equal to the error, which keeps limits easy to hit
    task automatic test_limit_modes();
        apply_settings(GAIN_ONE, GAIN_ONE, LIMIT_CLAMP, -32'sd1000, 32'sd1000);
        send_error(16'sd5000);
        send_error(-16'sd9000);
        send_error(16'sd300);
        apply_settings(GAIN_ONE, GAIN_ONE, LIMIT_WRAP, -32'sd500, 32'sd500);
        send_error(16'sd2000);
        send_error(-16'sd2000);
        apply_settings(GAIN_ONE, GAIN_ONE, LIMIT_SPARE, -32'sd10, 32'sd10);
        send_error(16'sd777);
        // Crossed limits: lower above upper
        apply_settings(GAIN_ONE, GAIN_ONE, LIMIT_CLAMP, 32'sd100, -32'sd100);
        send_error('0);
        apply_settings(GAIN_ONE, GAIN_ONE, LIMIT_WRAP, 32'sd100, -32'sd100);
        send_error('0);
    endtask

    // Pin the accumulator at one end with a degenerate clamp, then push past the width
    task automatic test_width_saturation();
        apply_settings(GAIN_TOP, GAIN_TOP, LIMIT_CLAMP, LIMIT_TOP, LIMIT_TOP);
        send_error(ERR_TOP);
        apply_settings(GAIN_TOP, GAIN_TOP, LIMIT_NONE, LIMIT_BOTTOM, LIMIT_TOP);
        send_error(ERR_TOP);
        send_error(ERR_TOP);
        send_error(ERR_BOTTOM);
        apply_settings(GAIN_TOP, GAIN_TOP, LIMIT_CLAMP, LIMIT_BOTTOM, LIMIT_BOTTOM);
        send_error(ERR_BOTTOM);
        apply_settings(GAIN_TOP, GAIN_TOP, LIMIT_NONE, LIMIT_BOTTOM, LIMIT_TOP);
        send_error(ERR_BOTTOM);
        send_error(ERR_BOTTOM);
        send_error(ERR_TOP);
    endtask

    // Random phases: new settings, traffic pattern and error style for each.
    // The first phase runs with no idling on either side.
    task automatic test_random_phases();
        int                          sent;
        int                          phase;
        int                          phase_len;
        err_style_e                  style;
        logic signed [ERR_WIDTH-1:0] steady;
        logic signed [LIMIT_W-1:0]   lower;
        logic signed [LIMIT_W-1:0]   upper;
        logic signed [LIMIT_W-1:0]   swap;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            lower = pick_limit();
            upper = pick_limit();
            // Keep most ranges ordered, leave some crossed
            if (lower > upper && $urandom_range(0, 3) != 0) begin
                swap  = lower;
                lower = upper;
                upper = swap;
            end
            apply_settings(pick_gain(), pick_gain(), pick_mode(), lower, upper);
            if (phase == 0) begin
                gaps_on     = 1'b0;
                ready_style = READY_ALWAYS;
            end else begin
                gaps_on      = ($urandom_range(0, 4) != 0);
                ready_style  = ready_style_e'($urandom_range(0, 2));
                ready_period = $urandom_range(2, 8);
                ready_hold   = $urandom_range(1, ready_period - 1);
            end
            // Steady setpoint tracking is the common case, the rest is noise
            case ($urandom_range(0, 9))
                0, 1:    style = ERR_FULL;
                2, 3:    style = ERR_SMALL;
                4:       style = ERR_CORNER;
                default: style = ERR_STEADY;
            endcase
            steady    = ERR_WIDTH'($urandom);
            phase_len = $urandom_range(20, 90);
            repeat (phase_len) begin
                send_error(next_error(style, steady));
                sent++;
            end
            phase++;
        end
    endtask

    initial begin
        kp_set     = '0;
        kit_set    = '0;
        mode_set   = LIMIT_NONE;
        lower_set  = LIMIT_BOTTOM;
        upper_set  = LIMIT_TOP;
        acc_model  = '0;
        last_error = '0;

        // Hold reset, then release
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_gain_extremes();
        test_limit_modes();
        test_width_saturation();
        test_random_phases();
        wait_idle();

        if (mismatches == 0) begin
            $display("pi_controller_velocity_sat verification clean");
        end else begin
            $display("pi_controller_velocity_sat verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/pcvs_pkg.sv
src/pcvs_increment.sv
src/pcvs_accumulate.sv
src/pi_controller_velocity_sat.sv
src/pcvs_checker.sv
verif/pi_controller_velocity_sat_test.sv
